// ===== hw/rtl/triv_pkg.sv =====
`timescale 1ns / 1ps

package triv_pkg;

	localparam int StateBits     = 288;
	localparam int KeyBits       = 80;
	localparam int IvOffset      = 93;
	localparam int BOffset       = 177;
	localparam int RoundsPerBeat = 8;
	localparam int WarmRounds    = 1152;
	localparam int WarmBeats     = WarmRounds / RoundsPerBeat;
	localparam int CntW          = $clog2(WarmBeats);
	localparam logic [CntW-1:0] WarmLast = CntW'(WarmBeats - 1);

	typedef logic [StateBits-1:0] state_vec_t;

	typedef enum logic [1:0] {
		REG_KEY_LOW  = 2'd0,
		REG_KEY_HIGH = 2'd1,
		REG_IV_LOW   = 2'd2,
		REG_IV_HIGH  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic load;     // reload state from key/IV, capture beat data
		logic advance;  // run one group of eight rounds
		logic out_load; // write result register
		logic sel_held; // result from captured data instead of live input
	} dp_cmd_t;

	typedef struct packed {
		state_vec_t  state;
		logic [7:0]  ks;
	} step_t;

	function automatic state_vec_t init_state(input logic [KeyBits-1:0] key,
		input logic [KeyBits-1:0] iv);
		state_vec_t s;
		s = '0;
		s[KeyBits-1:0] = key;
		s[IvOffset +: KeyBits] = iv;
		s[StateBits-1 -: 3] = 3'b111;
		return s;
	endfunction

	function automatic step_t run_beat(input state_vec_t s_in);
		state_vec_t s;
		state_vec_t nx;
		logic       t0;
		logic       t1;
		logic       t2;
		step_t      res;
		s = s_in;
		res.ks = '0;
		for (int r = 0; r < RoundsPerBeat; r++) begin
			t0 = s[65] ^ s[92];
			t1 = s[161] ^ s[176];
			t2 = s[242] ^ s[287];
			res.ks[r] = t0 ^ t1 ^ t2;
			t0 = t0 ^ (s[90] & s[91]) ^ s[170];
			t1 = t1 ^ (s[174] & s[175]) ^ s[263];
			t2 = t2 ^ (s[285] & s[286]) ^ s[68];
			nx = {s[StateBits-2:0], 1'b0};
			nx[0] = t2;
			nx[IvOffset] = t0;
			nx[BOffset] = t1;
			s = nx;
		end
		res.state = s;
		return res;
	endfunction

endpackage

// ===== hw/rtl/trivium_stream_cipher_unit.sv =====
`timescale 1ns / 1ps

// Trivium stream cipher: each input beat carries one byte in s_tdata and a start
// flag in s_tuser; the output beat is that byte XOR eight keystream bits, first
// keystream bit in bit 0. Eight cipher rounds are evaluated per clock, so beats
// without start stream at one per cycle unless the output stalls. A beat with
// start reloads the state from the key/IV registers and runs the 1152 warm-up
// rounds as 144 passes of the eight-round network; no input is taken until its
// result is registered. Write key/IV only while idle; they take effect at the
// next start beat. Every message must open with start.
module trivium_stream_cipher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_in
	input  logic        s_tuser,   // [0] start_req
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [7:0] data_out
);
	import triv_pkg::*;

	dp_cmd_t cmd;

	triv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.start_req (s_tuser),
		.m_tready  (m_tready),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.cmd       (cmd)
	);

	triv_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.data_in   (s_tdata),
		.cmd       (cmd),
		.data_out  (m_tdata)
	);

endmodule

// ===== hw/rtl/triv_ctrl.sv =====
`timescale 1ns / 1ps

module triv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              start_req,
	input  logic              m_tready,
	output logic              s_tready,
	output logic              m_tvalid,
	output triv_pkg::dp_cmd_t cmd
);
	import triv_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WARM = 3'b010,
		ST_GEN  = 3'b100
	} state_t;

	state_t          state_q;
	state_t          state_d;
	logic [CntW-1:0] cnt_q;
	logic            m_tvalid_q;
	logic            out_free;
	logic            accept;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (start_req) begin
						cmd.load = 1'b1;
						state_d  = ST_WARM;
					end else begin
						cmd.advance  = 1'b1;
						cmd.out_load = 1'b1;
					end
				end
			end
			ST_WARM: begin
				cmd.advance = 1'b1;
				if (cnt_q == WarmLast) begin
					state_d = ST_GEN;
				end
			end
			ST_GEN: begin
				if (out_free) begin
					cmd.advance  = 1'b1;
					cmd.out_load = 1'b1;
					cmd.sel_held = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WARM) begin
				cnt_q <= (cnt_q == WarmLast) ? '0 : cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE)
		else $error("ready outside idle");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("result overwritten");
	a_warm_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WARM && cnt_q == WarmLast) |=> state_q == ST_GEN)
		else $error("warm-up did not finish");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_WARM |-> cnt_q == '0)
		else $error("counter running outside warm-up");
`endif

endmodule

// ===== hw/rtl/triv_dp.sv =====
`timescale 1ns / 1ps

module triv_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	input  logic [7:0]        data_in,
	input  triv_pkg::dp_cmd_t cmd,
	output logic [7:0]        data_out
);
	import triv_pkg::*;

	logic [63:0] key_low_q;
	logic [15:0] key_high_q;
	logic [63:0] iv_low_q;
	logic [15:0] iv_high_q;
	state_vec_t  state_q;
	logic [7:0]  data_q;
	logic [7:0]  out_q;
	step_t       step;
	cfg_reg_t    reg_sel;

	assign reg_sel  = cfg_reg_t'(cfg_index);
	assign step     = run_beat(state_q);
	assign data_out = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			iv_low_q   <= '0;
			iv_high_q  <= '0;
			state_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (reg_sel)
					REG_KEY_LOW:  key_low_q  <= cfg_data;
					REG_KEY_HIGH: key_high_q <= cfg_data[15:0];
					REG_IV_LOW:   iv_low_q   <= cfg_data;
					REG_IV_HIGH:  iv_high_q  <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				state_q <= init_state({key_high_q, key_low_q}, {iv_high_q, iv_low_q});
			end else if (cmd.advance) begin
				state_q <= step.state;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			data_q <= data_in;
		end
		if (cmd.out_load) begin
			out_q <= (cmd.sel_held ? data_q : data_in) ^ step.ks;
		end
	end

endmodule

// ===== sim/trivium_stream_cipher_unit_tb.sv =====
`timescale 1ns / 1ps

module trivium_stream_cipher_unit_tb;
	import triv_pkg::*;

	localparam int WarmupRounds = 1152;
	localparam int IvBase       = 93;
	localparam int HoldCycles   = 400;
	localparam int PhaseItems   = 310;
	localparam int TailCycles   = 150;
	localparam int MaxReports   = 40;

	typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		cfg_reg_t    idx;
		logic [63:0] val;
		logic [7:0]  data;
		logic        start;
		logic        typed;
		logic [7:0]  want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	cfg_reg_t    cfg_index;
	logic [63:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_in
	logic        s_tuser;   // [0] start_req
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] data_out

	state_vec_t  tri_state;
	logic [63:0] key_lo;
	logic [15:0] key_hi;
	logic [63:0] iv_lo;
	logic [15:0] iv_hi;
	logic [7:0]  want_bytes_q[$];
	int          err_count = 0;
	int          src_idle = 15;
	int          sink_idle = 83;
	int          hold_req = 0;
	int          hold_ack;
	dir_row_t    dir_rows [23];

	trivium_stream_cipher_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic cipher_round();
		logic a;
		logic b;
		logic c;
		logic z;
		a = tri_state[65] ^ tri_state[92];
		b = tri_state[161] ^ tri_state[176];
		c = tri_state[242] ^ tri_state[287];
		z = a ^ b ^ c;
		a = a ^ (tri_state[90] & tri_state[91]) ^ tri_state[170];
		b = b ^ (tri_state[174] & tri_state[175]) ^ tri_state[263];
		c = c ^ (tri_state[285] & tri_state[286]) ^ tri_state[68];
		tri_state = {tri_state[286:0], 1'b0};
		tri_state[0] = c;
		tri_state[93] = a;
		tri_state[177] = b;
		return z;
	endfunction

	function automatic logic [7:0] encrypt_byte(input logic [7:0] d, input logic st);
		logic [7:0] ks;
		if (st) begin
			tri_state = '0;
			tri_state[79:0] = {key_hi, key_lo};
			tri_state[IvBase +: 80] = {iv_hi, iv_lo};
			tri_state[287:285] = 3'b111;
			repeat (WarmupRounds) void'(cipher_round());
		end
		for (int r = 0; r < 8; r++)
			ks[r] = cipher_round();
		return d ^ ks;
	endfunction

	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic flag_err(input string what, input logic [7:0] got, input logic [7:0] want);
		if (err_count < MaxReports)
			$display("tb: mismatch %s at %0t: got %02h want %02h", what, $time, got, want);
		err_count++;
	endtask

	// leaves tvalid high after the beat; callers that pause lower it
	task automatic send_byte(input logic [7:0] d, input logic st, input logic typed,
		input logic [7:0] want);
		logic [7:0] pred;
		cfg_we <= 1'b0;
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= st;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pred = encrypt_byte(d, st);
		want_bytes_q.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (want_bytes_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			REG_KEY_LOW:  key_lo = v;
			REG_KEY_HIGH: key_hi = v[15:0];
			REG_IV_LOW:   iv_lo = v;
			REG_IV_HIGH:  iv_hi = v[15:0];
		endcase
		@(negedge clk);
	endtask

	// output side: random backpressure plus one long counted hold-off on request
	initial begin
		m_tready = 1'b0;
		hold_ack = 0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_ack) begin
				m_tready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_ack = hold_ack + 1;
			end
			m_tready <= ($urandom_range(0, 99) >= sink_idle);
		end
	end

	always @(posedge clk) begin : out_mon
		logic [7:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (want_bytes_q.size() == 0) begin
				flag_err("unexpected beat", m_tdata, 8'h00);
			end else begin
				want = want_bytes_q.pop_front();
				if (m_tdata !== want)
					flag_err("data_out", m_tdata, want);
			end
		end
	end

	initial begin : stim
		int   sent;
		int   msg_len;
		logic st;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_LOW;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		tri_state = '0;
		key_lo = '0;
		key_hi = '0;
		iv_lo = '0;
		iv_hi = '0;

		// beats before any start see zero state: keystream is zero, data passes through
		dir_rows = '{
			'{ROW_BEAT, REG_KEY_LOW,  64'h0,                  8'h00, 1'b0, 1'b1, 8'h00},
			'{ROW_BEAT, REG_KEY_LOW,  64'h0,                  8'hFF, 1'b0, 1'b1, 8'hFF},
			'{ROW_BEAT, REG_KEY_LOW,  64'h0,                  8'hA5, 1'b0, 1'b1, 8'hA5},
			'{ROW_BEAT, REG_KEY_LOW,  64'h0,                  8'h5A, 1'b0, 1'b1, 8'h5A},
			'{ROW_BEAT, REG_KEY_LOW,  64'h0,                  8'h00, 1'b1, 1'b0, 8'h00},
			'{ROW_BEAT, REG_KEY_LOW,  64'h0,                  8'hFF, 1'b0, 1'b0, 8'h00},
			'{ROW_BEAT, REG_KEY_LOW,  64'h0,                  8'h3C, 1'b0, 1'b0, 8'h00},
			// all ones, upper bits of the short registers dropped; no effect mid-message
			'{ROW_CFG,  REG_KEY_LOW,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
			'{ROW_CFG,  REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
			'{ROW_CFG,  REG_IV_LOW,   64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
			'{ROW_CFG,  REG_IV_HIGH,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
			'{ROW_BEAT, REG_KEY_LOW,  64'h0,                  8'h81, 1'b0, 1'b0, 8'h00},
			'{ROW_BEAT, REG_KEY_LOW,  64'h0,                  8'hFF, 1'b1, 1'b0, 8'h00},
			'{ROW_BEAT, REG_KEY_LOW,  64'h0,                  8'h00, 1'b0, 1'b0, 8'h00},
			'{ROW_BEAT, REG_KEY_LOW,  64'h0,                  8'h7E, 1'b0, 1'b0, 8'h00},
			'{ROW_CFG,  REG_KEY_LOW,  64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 1'b0, 8'h00},
			'{ROW_CFG,  REG_KEY_HIGH, 64'hDEAD_0000_0000_8001, 8'h00, 1'b0, 1'b0, 8'h00},
			'{ROW_CFG,  REG_IV_LOW,   64'h8000_0000_0000_0001, 8'h00, 1'b0, 1'b0, 8'h00},
			'{ROW_CFG,  REG_IV_HIGH,  64'h0000_0000_0000_0000, 8'h00, 1'b0, 1'b0, 8'h00},
			'{ROW_BEAT, REG_KEY_LOW,  64'h0,                  8'h00, 1'b1, 1'b0, 8'h00},
			'{ROW_BEAT, REG_KEY_LOW,  64'h0,                  8'hFF, 1'b1, 1'b0, 8'h00},
			'{ROW_BEAT, REG_KEY_LOW,  64'h0,                  8'h55, 1'b0, 1'b0, 8'h00},
			'{ROW_BEAT, REG_KEY_LOW,  64'h0,                  8'hAA, 1'b0, 1'b0, 8'h00}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain_results();
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				send_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].typed,
					dir_rows[i].want);
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			drain_results();
			case (ph)
				0: begin src_idle = 15; sink_idle = 83; end
				1: begin src_idle = 83; sink_idle = 15; end
				default: begin src_idle = 0; sink_idle = 0; end
			endcase
			write_reg(REG_KEY_LOW, rand64());
			write_reg(REG_KEY_HIGH, rand64());
			write_reg(REG_IV_LOW, rand64());
			write_reg(REG_IV_HIGH, rand64());
			if (ph == 2)
				hold_req = hold_req + 1;
			sent = 0;
			while (sent < PhaseItems) begin
				if ($urandom_range(0, 3) == 0) begin
					drain_results();
					write_reg(cfg_reg_t'($urandom_range(0, 3)), rand64());
				end
				msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
					: $urandom_range(1, 16);
				for (int i = 0; i < msg_len; i++) begin
					// mostly proper messages; some without opening start, some restarts
					st = (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 49) == 0);
					send_byte(8'($urandom_range(0, 255)), st, 1'b0, 8'h00);
					sent++;
				end
			end
		end

		drain_results();
		repeat (TailCycles) @(posedge clk);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== trivium_stream_cipher_unit.f =====
hw/rtl/triv_pkg.sv
hw/rtl/triv_ctrl.sv
hw/rtl/triv_dp.sv
hw/rtl/trivium_stream_cipher_unit.sv
sim/trivium_stream_cipher_unit_tb.sv
